FILE: hw/rtl/rrdf_pkg.sv
// ----------------------------------------------------------------------------
// rrdf_pkg
// Shared types and constants of the radio range delivery filter.
// ----------------------------------------------------------------------------
package rrdf_pkg;

  localparam logic [1:0] ACT_CONNECT    = 2'd0;
  localparam logic [1:0] ACT_DISCONNECT = 2'd1;
  localparam logic [1:0] ACT_LOGIN      = 2'd2;
  localparam logic [1:0] ACT_DATA       = 2'd3;

  localparam logic [1:0] ST_DELIVER  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_NO_DEST  = 2'd3;

  localparam logic [15:0] NOT_LOGGED = 16'hFFFF;

  localparam logic [47:0] LCG_SEED   = 48'h1234ABCD330E;
  localparam logic [31:0] LCG_MUL_LO = 32'hDEECE66D;
  localparam logic [2:0]  LCG_MUL_HI = 3'd5;
  localparam logic [47:0] LCG_ADD    = 48'hB;

  localparam int ENTRY_W = 144;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_LOAD,
    S_DRAW,
    S_RANGE,
    S_MUL,
    S_SUM,
    S_CMP,
    S_EMIT_REJ,
    S_EMIT_OK,
    S_EMIT_DLV,
    S_EMIT_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    K_REJ,
    K_OK,
    K_DLV,
    K_DONE
  } out_kind_t;

  typedef struct packed {
    logic      latch_in;
    logic      set_use;
    logic      clr_use;
    logic      wr_connect;
    logic      wr_login;
    logic      load_src;
    logic      t_clear;
    logic      t_inc;
    logic      rd_walk;
    logic      load_diff;
    logic      draw;
    logic      calc_rng;
    logic      calc_mul;
    logic      calc_sum;
    logic      hit_set;
    logic      out_load;
    out_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       reject;
    logic       walk_end;
    logic       walk_skip;
    logic       need_draw;
    logic       in_range;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/rrdf_ram.sv
// ----------------------------------------------------------------------------
// rrdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rrdf_datapath.sv
// ----------------------------------------------------------------------------
// rrdf_datapath
// Slot table, random generator, range arithmetic and result register.
// ----------------------------------------------------------------------------
module rrdf_datapath #(
  parameter int NUM_SLOTS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        action,
  input  logic [3:0]        slot,
  input  logic [15:0]       msg_id,
  input  logic [31:0]       pos_x_in,
  input  logic [31:0]       pos_y_in,
  input  logic [31:0]       max_range_in,
  input  logic [31:0]       good_range_in,
  input  rrdf_pkg::dp_cmd_t cmd,
  output rrdf_pkg::dp_stat_t stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        status,
  output logic [3:0]        dest_slot,
  output logic              last
);

  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int TW  = $clog2(NUM_SLOTS + 1);
  localparam int RW  = 32 + FRAC_BITS;
  localparam int SQW = 2 * RW;
  localparam int DW  = 65 + 2 * FRAC_BITS;
  localparam int ENTRY_W_L = rrdf_pkg::ENTRY_W;
  localparam logic [31:0] LCG_MUL_LO_L = rrdf_pkg::LCG_MUL_LO;

  logic [1:0]           act_q;
  logic [3:0]           slot_q;
  logic [15:0]          id_q;
  logic [31:0]          x_q, y_q, mx_q, gd_q;
  logic [NUM_SLOTS-1:0] in_use;
  logic [31:0]          sx, sy, smx, sgd;
  logic [TW-1:0]        t;
  logic                 hit;
  logic [47:0]          lcg;
  logic [31:0]          dx, dy;
  logic [RW-1:0]        rng;
  logic [63:0]          p_ll, p_xx, p_yy;
  logic [RW-1:0]        p_hl;
  logic [2*FRAC_BITS-1:0] p_hh;
  logic [SQW-1:0]       rng_sq;
  logic [64:0]          dsq;

  logic [SW-1:0]        s_idx, t_idx;
  logic                 slot_ok;
  logic                 reject;
  logic                 ram_we, ram_re;
  logic [SW-1:0]        ram_raddr;
  logic [ENTRY_W_L-1:0] ram_wdata, ram_rdata;
  logic [15:0]          r_id;
  logic [31:0]          r_x, r_y, r_mx, r_gd;

  logic [55:0]          lp0;
  logic [26:0]          lp1;
  logic [47:0]          lp2;
  logic [47:0]          lcg_next;
  logic [FRAC_BITS-1:0] frac;
  logic [31:0]          rdiff;
  logic [RW-1:0]        rprod;
  logic [RW-1:0]        rng_next;
  logic [FRAC_BITS-1:0] rh;
  logic [31:0]          rl;
  logic [DW-1:0]        dist_sh;
  logic [DW-1:0]        rng_sq_ext;

  assign s_idx   = SW'(slot_q);
  assign t_idx   = t[SW-1:0];
  assign slot_ok = 32'(slot_q) < NUM_SLOTS;

  assign r_id = ram_rdata[143:128];
  assign r_x  = ram_rdata[127:96];
  assign r_y  = ram_rdata[95:64];
  assign r_mx = ram_rdata[63:32];
  assign r_gd = ram_rdata[31:0];

  assign ram_we    = cmd.wr_connect | cmd.wr_login;
  assign ram_re    = cmd.latch_in | cmd.rd_walk;
  assign ram_raddr = cmd.latch_in ? SW'(slot) : t_idx;
  assign ram_wdata = cmd.wr_login ? {id_q, x_q, y_q, mx_q, gd_q}
                                  : {rrdf_pkg::NOT_LOGGED, 128'd0};

  rrdf_ram #(
    .WIDTH(ENTRY_W_L),
    .DEPTH(NUM_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s_idx),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    reject = 1'b0;
    case (act_q)
      rrdf_pkg::ACT_CONNECT:    reject = in_use[s_idx];
      rrdf_pkg::ACT_DISCONNECT: reject = !in_use[s_idx];
      rrdf_pkg::ACT_LOGIN:      reject = !in_use[s_idx] || r_id != rrdf_pkg::NOT_LOGGED;
      rrdf_pkg::ACT_DATA: begin
        reject = !in_use[s_idx] || r_id == rrdf_pkg::NOT_LOGGED || r_id != id_q;
      end
      default: reject = 1'b1;
    endcase
    if (!slot_ok) begin
      reject = 1'b1;
    end
  end

  assign stat.reject    = reject;
  assign stat.act       = act_q;
  assign stat.walk_end  = (t == TW'(NUM_SLOTS));
  assign stat.walk_skip = (32'(t) == 32'(slot_q)) || !in_use[t_idx];
  assign stat.need_draw = smx > sgd;
  assign stat.out_free  = !out_valid || !out_stall;

  assign lp0      = lcg[23:0] * LCG_MUL_LO_L;
  assign lp1      = lcg[23:0] * rrdf_pkg::LCG_MUL_HI;
  assign lp2      = lcg[47:24] * LCG_MUL_LO_L[23:0];
  assign lcg_next = lp0[47:0] + {lp1[15:0], 32'd0} + {lp2[23:0], 24'd0}
                  + rrdf_pkg::LCG_ADD;
  assign frac     = lcg[47 -: FRAC_BITS];

  assign rdiff    = smx - sgd;
  assign rprod    = rdiff * frac;
  assign rng_next = stat.need_draw ? ({sgd, {FRAC_BITS{1'b0}}} + rprod)
                                   : {smx, {FRAC_BITS{1'b0}}};

  assign rh = rng[RW-1:32];
  assign rl = rng[31:0];

  assign dist_sh    = {dsq, {(2 * FRAC_BITS){1'b0}}};
  assign rng_sq_ext = DW'(rng_sq);
  assign stat.in_range = dist_sh < rng_sq_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_q  <= action;
      slot_q <= slot;
      id_q   <= msg_id;
      x_q    <= pos_x_in;
      y_q    <= pos_y_in;
      mx_q   <= max_range_in;
      gd_q   <= good_range_in;
    end
    if (cmd.load_src) begin
      sx  <= r_x;
      sy  <= r_y;
      smx <= r_mx;
      sgd <= r_gd;
    end
    if (cmd.load_diff) begin
      dx <= (sx > r_x) ? (sx - r_x) : (r_x - sx);
      dy <= (sy > r_y) ? (sy - r_y) : (r_y - sy);
    end
    if (cmd.calc_rng) begin
      rng <= rng_next;
    end
    if (cmd.calc_mul) begin
      p_ll <= rl * rl;
      p_hl <= rh * rl;
      p_hh <= rh * rh;
      p_xx <= dx * dx;
      p_yy <= dy * dy;
    end
    if (cmd.calc_sum) begin
      rng_sq <= (SQW'(p_hh) << 64) + (SQW'(p_hl) << 33) + SQW'(p_ll);
      dsq    <= 65'(p_xx) + 65'(p_yy);
    end
    if (cmd.out_load) begin
      case (cmd.out_kind)
        rrdf_pkg::K_REJ: begin
          status    <= rrdf_pkg::ST_REJECTED;
          dest_slot <= 4'd0;
          last      <= 1'b1;
        end
        rrdf_pkg::K_OK: begin
          status    <= rrdf_pkg::ST_ACCEPTED;
          dest_slot <= 4'd0;
          last      <= 1'b1;
        end
        rrdf_pkg::K_DLV: begin
          status    <= rrdf_pkg::ST_DELIVER;
          dest_slot <= 4'(t);
          last      <= 1'b0;
        end
        default: begin
          status    <= hit ? rrdf_pkg::ST_ACCEPTED : rrdf_pkg::ST_NO_DEST;
          dest_slot <= 4'd0;
          last      <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      lcg       <= rrdf_pkg::LCG_SEED;
      t         <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_use) begin
        in_use[s_idx] <= 1'b1;
      end
      if (cmd.clr_use) begin
        in_use[s_idx] <= 1'b0;
      end
      if (cmd.draw) begin
        lcg <= lcg_next;
      end
      if (cmd.t_clear) begin
        t <= '0;
      end else if (cmd.t_inc) begin
        t <= t + TW'(1);
      end
      if (cmd.load_src) begin
        hit <= 1'b0;
      end else if (cmd.hit_set) begin
        hit <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/rrdf_ctrl.sv
// ----------------------------------------------------------------------------
// rrdf_ctrl
// Sequencer that checks each transaction and walks the slot table.
// ----------------------------------------------------------------------------
module rrdf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrdf_pkg::dp_stat_t stat,
  output rrdf_pkg::dp_cmd_t  cmd
);

  rrdf_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrdf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_kind = rrdf_pkg::K_REJ;
    in_stall     = 1'b1;
    case (state)
      rrdf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = rrdf_pkg::S_CHECK;
        end
      end
      rrdf_pkg::S_CHECK: begin
        if (stat.reject) begin
          state_next = rrdf_pkg::S_EMIT_REJ;
        end else begin
          case (stat.act)
            rrdf_pkg::ACT_CONNECT: begin
              cmd.set_use    = 1'b1;
              cmd.wr_connect = 1'b1;
              state_next     = rrdf_pkg::S_EMIT_OK;
            end
            rrdf_pkg::ACT_DISCONNECT: begin
              cmd.clr_use = 1'b1;
              state_next  = rrdf_pkg::S_EMIT_OK;
            end
            rrdf_pkg::ACT_LOGIN: begin
              cmd.wr_login = 1'b1;
              state_next   = rrdf_pkg::S_EMIT_OK;
            end
            default: begin
              cmd.load_src = 1'b1;
              cmd.t_clear  = 1'b1;
              state_next   = rrdf_pkg::S_WALK;
            end
          endcase
        end
      end
      rrdf_pkg::S_WALK: begin
        if (stat.walk_end) begin
          state_next = rrdf_pkg::S_EMIT_DONE;
        end else if (stat.walk_skip) begin
          cmd.t_inc = 1'b1;
        end else begin
          cmd.rd_walk = 1'b1;
          state_next  = rrdf_pkg::S_LOAD;
        end
      end
      rrdf_pkg::S_LOAD: begin
        cmd.load_diff = 1'b1;
        state_next    = stat.need_draw ? rrdf_pkg::S_DRAW : rrdf_pkg::S_RANGE;
      end
      rrdf_pkg::S_DRAW: begin
        cmd.draw   = 1'b1;
        state_next = rrdf_pkg::S_RANGE;
      end
      rrdf_pkg::S_RANGE: begin
        cmd.calc_rng = 1'b1;
        state_next   = rrdf_pkg::S_MUL;
      end
      rrdf_pkg::S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = rrdf_pkg::S_SUM;
      end
      rrdf_pkg::S_SUM: begin
        cmd.calc_sum = 1'b1;
        state_next   = rrdf_pkg::S_CMP;
      end
      rrdf_pkg::S_CMP: begin
        if (stat.in_range) begin
          state_next = rrdf_pkg::S_EMIT_DLV;
        end else begin
          cmd.t_inc  = 1'b1;
          state_next = rrdf_pkg::S_WALK;
        end
      end
      rrdf_pkg::S_EMIT_REJ: begin
        cmd.out_kind = rrdf_pkg::K_REJ;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rrdf_pkg::S_IDLE;
        end
      end
      rrdf_pkg::S_EMIT_OK: begin
        cmd.out_kind = rrdf_pkg::K_OK;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rrdf_pkg::S_IDLE;
        end
      end
      rrdf_pkg::S_EMIT_DLV: begin
        cmd.out_kind = rrdf_pkg::K_DLV;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.hit_set  = 1'b1;
          cmd.t_inc    = 1'b1;
          state_next   = rrdf_pkg::S_WALK;
        end
      end
      rrdf_pkg::S_EMIT_DONE: begin
        cmd.out_kind = rrdf_pkg::K_DONE;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rrdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rrdf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/radio_range_delivery_filter_unit.sv
// ----------------------------------------------------------------------------
// radio_range_delivery_filter_unit
// Connection table with radio range filtering of data transactions.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Connect, disconnect, login and any
// rejected transaction pass through accept with a table read, check, and
// result. A data transaction walks the slot table after the check: each
// skipped slot takes one walk step, and each other connected slot goes
// through table read, difference, a random draw when needed, range,
// squaring, sum and compare, plus a delivery result when it is in range.
// The walk ends with a closing result. A stalled result holds the
// block at that point. The table has no clearing pass: slot contents are
// written when a slot connects.
module radio_range_delivery_filter_unit #(
  parameter int NUM_SLOTS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [3:0]  slot,
  input  logic [15:0] msg_id,
  input  logic [31:0] pos_x_in,
  input  logic [31:0] pos_y_in,
  input  logic [31:0] max_range_in,
  input  logic [31:0] good_range_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  dest_slot,
  output logic        last
);

  rrdf_pkg::dp_cmd_t  cmd;
  rrdf_pkg::dp_stat_t stat;

  rrdf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  rrdf_datapath #(
    .NUM_SLOTS(NUM_SLOTS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .slot         (slot),
    .msg_id       (msg_id),
    .pos_x_in     (pos_x_in),
    .pos_y_in     (pos_y_in),
    .max_range_in (max_range_in),
    .good_range_in(good_range_in),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .dest_slot    (dest_slot),
    .last         (last)
  );

endmodule

FILE: tb/radio_range_delivery_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// radio_range_delivery_filter_unit_tb
// Self-checking testbench for the radio range delivery filter. A queue of
// directed and random transactions feeds a clocked driver. On each accepted
// transaction a predictor of the slot table and the 48-bit generator forms
// the expected results, which a clocked monitor compares field by field.
// ----------------------------------------------------------------------------
module radio_range_delivery_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  act;
    logic [3:0]  sl;
    logic [15:0] id;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] mx;
    logic [31:0] gd;
    bit          hold;
  } txn_t;

  typedef struct {
    logic [1:0] st;
    logic [3:0] dest;
    logic       lst;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [3:0] slot = '0;
  logic [15:0] msg_id = '0;
  logic [31:0] pos_x_in = '0, pos_y_in = '0, max_range_in = '0, good_range_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [3:0] dest_slot;
  logic last;

  radio_range_delivery_filter_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .slot(slot), .msg_id(msg_id), .pos_x_in(pos_x_in),
    .pos_y_in(pos_y_in), .max_range_in(max_range_in), .good_range_in(good_range_in),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .dest_slot(dest_slot), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  txn_t pending_q[$];
  res_t result_q[$];
  int   mismatches = 0;
  int   accepted = 0;
  int   idle_cycles = 0;
  bit   quiet = 0;
  bit   took = 0;

  // Predicted table.
  bit          p_used[16];
  logic [15:0] p_ident[16];
  logic [31:0] p_x[16], p_y[16], p_max[16], p_good[16];
  logic [47:0] p_lcg;

  // Shadow used only to shape well-formed stimulus.
  bit          g_used[16];
  logic [15:0] g_ident[16];

  task automatic push_res(input logic [1:0] st, input logic [3:0] dest, input logic lst);
    res_t r;
    r.st = st;
    r.dest = dest;
    r.lst = lst;
    result_q.push_back(r);
  endtask

  function automatic bit reach(input int s, input int t);
    logic [63:0]  rng;
    logic [63:0]  dx, dy;
    logic [127:0] dsq, rsq;
    if (p_max[s] <= p_good[s]) begin
      rng = {16'd0, p_max[s], 16'd0};
    end else begin
      p_lcg = p_lcg * 48'h5DEECE66D + rrdf_pkg::LCG_ADD;
      rng = ({32'd0, p_good[s]} << 16) + {32'd0, p_max[s] - p_good[s]} * {48'd0, p_lcg[47:32]};
    end
    dx = (p_x[s] > p_x[t]) ? {32'd0, p_x[s] - p_x[t]} : {32'd0, p_x[t] - p_x[s]};
    dy = (p_y[s] > p_y[t]) ? {32'd0, p_y[s] - p_y[t]} : {32'd0, p_y[t] - p_y[s]};
    dsq = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
    rsq = {64'd0, rng} * {64'd0, rng};
    return (dsq << 32) < rsq;
  endfunction

  task automatic clear_entry(input int s);
    p_used[s] = 0;
    p_ident[s] = rrdf_pkg::NOT_LOGGED;
    p_x[s] = '0;
    p_y[s] = '0;
    p_max[s] = '0;
    p_good[s] = '0;
  endtask

  task automatic predict_delivery(input txn_t tx);
    int s;
    int hits;
    s = tx.sl;
    hits = 0;
    case (tx.act)
      rrdf_pkg::ACT_CONNECT: begin
        if (p_used[s]) push_res(rrdf_pkg::ST_REJECTED, 4'd0, 1'b1);
        else begin
          clear_entry(s);
          p_used[s] = 1;
          push_res(rrdf_pkg::ST_ACCEPTED, 4'd0, 1'b1);
        end
      end
      rrdf_pkg::ACT_DISCONNECT: begin
        if (!p_used[s]) push_res(rrdf_pkg::ST_REJECTED, 4'd0, 1'b1);
        else begin
          clear_entry(s);
          push_res(rrdf_pkg::ST_ACCEPTED, 4'd0, 1'b1);
        end
      end
      rrdf_pkg::ACT_LOGIN: begin
        if (!p_used[s] || p_ident[s] != rrdf_pkg::NOT_LOGGED) begin
          push_res(rrdf_pkg::ST_REJECTED, 4'd0, 1'b1);
        end else begin
          p_ident[s] = tx.id;
          p_x[s] = tx.x;
          p_y[s] = tx.y;
          p_max[s] = tx.mx;
          p_good[s] = tx.gd;
          push_res(rrdf_pkg::ST_ACCEPTED, 4'd0, 1'b1);
        end
      end
      default: begin
        if (!p_used[s] || p_ident[s] == rrdf_pkg::NOT_LOGGED || p_ident[s] != tx.id) begin
          push_res(rrdf_pkg::ST_REJECTED, 4'd0, 1'b1);
        end else begin
          for (int t = 0; t < 16; t++) begin
            if (t != s && p_used[t] && reach(s, t)) begin
              push_res(rrdf_pkg::ST_DELIVER, 4'(t), 1'b0);
              hits++;
            end
          end
          push_res(hits > 0 ? rrdf_pkg::ST_ACCEPTED : rrdf_pkg::ST_NO_DEST, 4'd0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic add_txn(input logic [1:0] a, input logic [3:0] s, input logic [15:0] id,
                         input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] mx, input logic [31:0] gd);
    txn_t tx;
    tx.act = a;
    tx.sl = s;
    tx.id = id;
    tx.x = x;
    tx.y = y;
    tx.mx = mx;
    tx.gd = gd;
    tx.hold = 0;
    case (a)
      rrdf_pkg::ACT_CONNECT: if (!g_used[s]) begin
        g_used[s] = 1;
        g_ident[s] = rrdf_pkg::NOT_LOGGED;
      end
      rrdf_pkg::ACT_DISCONNECT: if (g_used[s]) begin
        g_used[s] = 0;
        g_ident[s] = rrdf_pkg::NOT_LOGGED;
      end
      rrdf_pkg::ACT_LOGIN: begin
        if (g_used[s] && g_ident[s] == rrdf_pkg::NOT_LOGGED) g_ident[s] = id;
      end
      default: ;
    endcase
    pending_q.push_back(tx);
  endtask

  // Driver.
  int snd_gap = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || took)) begin
      if (snd_gap > 0) begin
        snd_gap <= snd_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snd_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].hold && result_q.size() != 0)) begin
        txn_t tx;
        tx = pending_q.pop_front();
        in_valid <= 1'b1;
        action <= tx.act;
        slot <= tx.sl;
        msg_id <= tx.id;
        pos_x_in <= tx.x;
        pos_y_in <= tx.y;
        max_range_in <= tx.mx;
        good_range_in <= tx.gd;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall.
  int rcv_gap = 0;
  int hold_off = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (!hold_done && accepted == 150) begin
      hold_done <= 1;
      hold_off <= 300;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      rcv_gap <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Predictor and monitor.
  always @(posedge clk) begin
    took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        txn_t tx;
        tx.act = action;
        tx.sl = slot;
        tx.id = msg_id;
        tx.x = pos_x_in;
        tx.y = pos_y_in;
        tx.mx = max_range_in;
        tx.gd = good_range_in;
        tx.hold = 0;
        predict_delivery(tx);
        accepted <= accepted + 1;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status=%0d dest=%0d last=%0d",
                     status, dest_slot, last);
        end else begin
          res_t r;
          r = result_q.pop_front();
          if (r.st !== status || r.dest !== dest_slot || r.lst !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status=%0d dest=%0d last=%0d, got %0d %0d %0d",
                       r.st, r.dest, r.lst, status, dest_slot, last);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int s;
    int r;
    int cnt;
    for (int i = 0; i < 16; i++) begin
      clear_entry(i);
      g_used[i] = 0;
      g_ident[i] = rrdf_pkg::NOT_LOGGED;
    end
    p_lcg = rrdf_pkg::LCG_SEED;

    add_txn(rrdf_pkg::ACT_DATA, 4'd1, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_CONNECT, 4'd0, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_CONNECT, 4'd0, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_LOGIN, 4'd0, 16'd7, 32'd100, 32'd100, 32'd400, 32'd50);
    add_txn(rrdf_pkg::ACT_LOGIN, 4'd0, 16'd8, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DATA, 4'd0, 16'd9, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_CONNECT, 4'd1, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DATA, 4'd1, rrdf_pkg::NOT_LOGGED, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_LOGIN, 4'd1, rrdf_pkg::NOT_LOGGED, 32'd120, 32'd90,
            32'd10, 32'd10);
    add_txn(rrdf_pkg::ACT_DATA, 4'd1, rrdf_pkg::NOT_LOGGED, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_LOGIN, 4'd1, 16'd0, 32'd120, 32'd90, 32'd30, 32'd40);
    add_txn(rrdf_pkg::ACT_CONNECT, 4'd15, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_LOGIN, 4'd15, 16'hFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'h0);
    add_txn(rrdf_pkg::ACT_CONNECT, 4'd2, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DATA, 4'd0, 16'd7, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DATA, 4'd1, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DATA, 4'd15, 16'hFFFE, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DISCONNECT, 4'd3, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DISCONNECT, 4'd2, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_DISCONNECT, 4'd15, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_CONNECT, 4'd15, 16'd0, '0, '0, '0, '0);
    add_txn(rrdf_pkg::ACT_LOGIN, 4'd15, 16'd3, 32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_txn(rrdf_pkg::ACT_DATA, 4'd15, 16'd3, '0, '0, '0, '0);

    cnt = 0;
    while (cnt < 470) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 15);
      if (r < 20) begin
        add_txn(2'($urandom), 4'($urandom), 16'($urandom), $urandom, $urandom,
                $urandom, $urandom);
      end else if (!g_used[s]) begin
        add_txn(rrdf_pkg::ACT_CONNECT, 4'(s), 16'($urandom), '0, '0, '0, '0);
      end else if (g_ident[s] == rrdf_pkg::NOT_LOGGED) begin
        add_txn(rrdf_pkg::ACT_LOGIN, 4'(s), 16'($urandom_range(0, 16'hFFFE)),
                $urandom_range(0, 1000), $urandom_range(0, 1000),
                $urandom_range(0, 1500), $urandom_range(0, 1000));
      end else if (r < 80) begin
        add_txn(rrdf_pkg::ACT_DATA, 4'(s), g_ident[s], $urandom, $urandom,
                $urandom, $urandom);
      end else if (r < 90) begin
        add_txn(rrdf_pkg::ACT_DISCONNECT, 4'(s), 16'($urandom), '0, '0, '0, '0);
      end else begin
        add_txn(rrdf_pkg::ACT_DATA, 4'(s), g_ident[s] ^ 16'($urandom_range(1, 16'hFFFF)),
                '0, '0, '0, '0);
      end
      cnt++;
      if (cnt == 250) pending_q[pending_q.size() - 1].hold = 1;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 60) @(posedge clk);
    quiet = 1;
    while (pending_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: radio_range_delivery_filter_unit.f
hw/rtl/rrdf_pkg.sv
hw/rtl/rrdf_ram.sv
hw/rtl/rrdf_datapath.sv
hw/rtl/rrdf_ctrl.sv
hw/rtl/radio_range_delivery_filter_unit.sv
tb/radio_range_delivery_filter_unit_tb.sv
